// ===== design/dd_odom_pkg.sv =====
// Shared package for the differential drive odometry block.
// Widths, register map, reset values and the CORDIC arctangent table.
// No dependencies.
package dd_odom_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CFG_ADDR_W       = 5;
    localparam int MUL_A_W          = 25;
    localparam int MUL_B_W          = 33;
    localparam int MUL_P_W          = MUL_A_W + MUL_B_W;
    localparam int DIST_W           = 40;
    localparam int ACC_W            = 48;

    localparam logic [23:0] LEFT_DPC_RST  = 24'd7340;
    localparam logic [23:0] RIGHT_DPC_RST = 24'd7340;
    localparam logic [31:0] TURN_RST      = 32'd7119735;
    localparam logic [23:0] GYRO_APC_RST  = 24'd683565;

    localparam logic signed [33:0] CORDIC_START = 34'sh026DD3B6A;
    localparam logic signed [32:0] QUARTER_TURN = 33'sd1073741824;
    localparam logic signed [32:0] HALF_TURN    = 33'sd2147483648;

    typedef enum logic [2:0] {
        REG_LEFT_DPC  = 3'd0,
        REG_RIGHT_DPC = 3'd1,
        REG_TURN      = 3'd2,
        REG_USE_GYRO  = 3'd3,
        REG_GYRO_OFS  = 3'd4,
        REG_GYRO_APC  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic signed [32:0]    cos_v;
        logic signed [32:0]    sin_v;
    } cordic_res_t;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

// ===== design/dd_odom_if.sv =====
// Valid/ready channel interfaces for encoder samples and pose words.
// Depends on nothing.
interface dd_odom_in_if;
    logic               valid;
    logic               ready;
    logic [15:0]        left_count;
    logic [15:0]        right_count;
    logic signed [15:0] gyro_rate;

    modport source (output valid, left_count, right_count, gyro_rate, input ready);
    modport sink   (input valid, left_count, right_count, gyro_rate, output ready);
endinterface

interface dd_odom_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic signed [31:0] heading;

    modport source (output valid, x_pos, y_pos, heading, input ready);
    modport sink   (input valid, x_pos, y_pos, heading, output ready);
endinterface

// ===== design/dd_odom_mul.sv =====
// Shared signed multiplier with registered product.
// Depends on dd_odom_pkg.
module dd_odom_mul
    import dd_odom_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [MUL_P_W-1:0] prod
);

    logic signed [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// ===== design/dd_odom_cordic.sv =====
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on dd_odom_pkg (arctangent table, start vector).
module dd_odom_cordic
    import dd_odom_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] angle,
    output cordic_res_t res
);

    localparam int CNT_W = $clog2(STEPS);

    logic                    busy_reg;
    logic                    done_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    neg_reg;
    logic signed [33:0]      x_reg;
    logic signed [33:0]      y_reg;
    logic signed [32:0]      z_reg;

    logic signed [32:0]      a_ext;
    logic signed [32:0]      z_fold;
    logic                    neg_fold;
    logic signed [33:0]      x_sh;
    logic signed [33:0]      y_sh;
    logic signed [32:0]      atan_v;

    // fold into [-1/4, 1/4] turn
    always_comb
    begin
        a_ext = {angle[31], angle};
        priority if (a_ext > QUARTER_TURN)
        begin
            z_fold   = a_ext - HALF_TURN;
            neg_fold = 1'b1;
        end
        else if (a_ext < -QUARTER_TURN)
        begin
            z_fold   = a_ext + HALF_TURN;
            neg_fold = 1'b1;
        end
        else
        begin
            z_fold   = a_ext;
            neg_fold = 1'b0;
        end
    end

    assign x_sh   = x_reg >>> cnt_reg;
    assign y_sh   = y_reg >>> cnt_reg;
    assign atan_v = {1'b0, ATAN_TAB[5'(cnt_reg)]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= CORDIC_START;
            y_reg   <= '0;
            z_reg   <= z_fold;
            neg_reg <= neg_fold;
        end
        else if (busy_reg)
        begin
            if (!z_reg[32])
            begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - atan_v;
            end
            else
            begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + atan_v;
            end
        end
    end

    always_comb
    begin
        res.busy  = busy_reg;
        res.done  = done_reg;
        res.cos_v = neg_reg ? 33'(-x_reg) : 33'(x_reg);
        res.sin_v = neg_reg ? 33'(-y_reg) : 33'(y_reg);
    end

endmodule

// ===== design/differential_drive_odometry.sv =====
// Differential drive odometry: one pose word per encoder/gyro word.
// A word is taken only in the idle state, so no new word is accepted until the last pose is
// registered; the iterative CORDIC and the shared multiplier, doing the products of each word in
// turn, set the pace, gyro mode skips the T3 state, and a stalled pose output holds the block.
// rst_n async low: registers to defaults, counts, pose and heading to zero.
// Depends on dd_odom_pkg, dd_odom_if, dd_odom_mul, dd_odom_cordic.
module differential_drive_odometry
    import dd_odom_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    dd_odom_in_if.sink            sample,
    dd_odom_out_if.source         pose
);

    typedef enum logic [3:0] {
        S_IDLE, S_ML, S_MR, S_DIFF, S_T1, S_T2, S_T3, S_CST, S_CWAIT,
        S_PX1, S_PX2, S_PX3, S_PY2, S_PY3, S_OUT
    } state_t;

    state_t state_reg;

    // config
    logic [23:0]        left_dpc_reg;
    logic [23:0]        right_dpc_reg;
    logic [31:0]        turn_reg;
    logic               use_gyro_reg;
    logic [15:0]        gyro_ofs_reg;
    logic [23:0]        gyro_apc_reg;
    reg_idx_t           cfg_idx;

    // state
    logic [15:0]        prev_left_reg;
    logic [15:0]        prev_right_reg;
    logic [ACC_W-1:0]   xacc_reg;
    logic [ACC_W-1:0]   yacc_reg;
    logic [31:0]        heading_reg;
    logic               out_valid_reg;
    logic [31:0]        x_out_reg;
    logic [31:0]        y_out_reg;
    logic [31:0]        h_out_reg;

    // work registers
    logic signed [16:0]        dcl_reg;
    logic signed [16:0]        dcr_reg;
    logic signed [16:0]        corr_reg;
    logic signed [DIST_W-1:0]  dl_reg;
    logic signed [DIST_W:0]    diff_reg;
    logic signed [DIST_W-1:0]  mean_reg;
    logic [31:0]               t1_reg;
    logic signed [MUL_P_W-1:0] p1_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;
    logic signed [DIST_W:0]    dist_sum;
    logic signed [MUL_P_W-1:0] pos_sum;
    logic [ACC_W-1:0]          pos_step;
    logic                      cordic_start;
    cordic_res_t               cres;
    logic signed [MUL_A_W-1:0] mean_lo;
    logic signed [MUL_A_W-1:0] mean_hi;

    assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_dpc_reg  <= LEFT_DPC_RST;
            right_dpc_reg <= RIGHT_DPC_RST;
            turn_reg      <= TURN_RST;
            use_gyro_reg  <= 1'b0;
            gyro_ofs_reg  <= '0;
            gyro_apc_reg  <= GYRO_APC_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (cfg_idx)
                REG_LEFT_DPC:  left_dpc_reg  <= pwdata[23:0];
                REG_RIGHT_DPC: right_dpc_reg <= pwdata[23:0];
                REG_TURN:      turn_reg      <= pwdata;
                REG_USE_GYRO:  use_gyro_reg  <= pwdata[0];
                REG_GYRO_OFS:  gyro_ofs_reg  <= pwdata[15:0];
                REG_GYRO_APC:  gyro_apc_reg  <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_LEFT_DPC:  prdata = {8'b0, left_dpc_reg};
            REG_RIGHT_DPC: prdata = {8'b0, right_dpc_reg};
            REG_TURN:      prdata = turn_reg;
            REG_USE_GYRO:  prdata = {31'b0, use_gyro_reg};
            REG_GYRO_OFS:  prdata = {16'b0, gyro_ofs_reg};
            REG_GYRO_APC:  prdata = {8'b0, gyro_apc_reg};
            default:       prdata = '0;
        endcase
    end

    assign mean_lo = {9'b0, mean_reg[15:0]};
    assign mean_hi = {mean_reg[DIST_W-1], mean_reg[DIST_W-1:16]};

    // multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            S_ML:
            begin
                mul_a = {{8{dcl_reg[16]}}, dcl_reg};
                mul_b = {9'b0, left_dpc_reg};
            end
            S_MR:
            begin
                mul_a = {{8{dcr_reg[16]}}, dcr_reg};
                mul_b = {9'b0, right_dpc_reg};
            end
            S_T1:
            begin
                if (use_gyro_reg)
                begin
                    mul_a = {{8{corr_reg[16]}}, corr_reg};
                    mul_b = {9'b0, gyro_apc_reg};
                end
                else
                begin
                    mul_a = diff_reg[DIST_W:16];
                    mul_b = {1'b0, turn_reg};
                end
            end
            S_T2:
            begin
                mul_a = {9'b0, diff_reg[15:0]};
                mul_b = {1'b0, turn_reg};
            end
            S_PX1:
            begin
                mul_a = mean_lo;
                mul_b = cres.cos_v;
            end
            S_PX2:
            begin
                mul_a = mean_hi;
                mul_b = cres.cos_v;
            end
            S_PX3:
            begin
                mul_a = mean_lo;
                mul_b = cres.sin_v;
            end
            S_PY2:
            begin
                mul_a = mean_hi;
                mul_b = cres.sin_v;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    dd_odom_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign cordic_start = (state_reg == S_CST);

    dd_odom_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .angle (heading_reg),
        .res   (cres)
    );

    assign dist_sum = {prod[DIST_W-1], prod[DIST_W-1:0]} + {dl_reg[DIST_W-1], dl_reg};
    // floor(mean * trig / 2^30) = floor((hi*k + floor(lo*k / 2^16)) / 2^14)
    assign pos_sum  = prod + (p1_reg >>> 16);
    assign pos_step = {{4{pos_sum[MUL_P_W-1]}}, pos_sum[MUL_P_W-1:14]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            xacc_reg       <= '0;
            yacc_reg       <= '0;
            heading_reg    <= '0;
            out_valid_reg  <= 1'b0;
            x_out_reg      <= '0;
            y_out_reg      <= '0;
            h_out_reg      <= '0;
        end
        else
        begin
            if (out_valid_reg && pose.ready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (sample.valid)
                    begin
                        prev_left_reg  <= sample.left_count;
                        prev_right_reg <= sample.right_count;
                        state_reg      <= S_ML;
                    end
                end
                S_ML:    state_reg <= S_MR;
                S_MR:    state_reg <= S_DIFF;
                S_DIFF:  state_reg <= S_T1;
                S_T1:    state_reg <= S_T2;
                S_T2:
                begin
                    if (use_gyro_reg)
                    begin
                        heading_reg <= heading_reg + prod[31:0];
                        state_reg   <= S_CST;
                    end
                    else
                    begin
                        state_reg <= S_T3;
                    end
                end
                S_T3:
                begin
                    heading_reg <= heading_reg + t1_reg + prod[47:16];
                    state_reg   <= S_CST;
                end
                S_CST:   state_reg <= S_CWAIT;
                S_CWAIT:
                begin
                    if (cres.done)
                    begin
                        state_reg <= S_PX1;
                    end
                end
                S_PX1:   state_reg <= S_PX2;
                S_PX2:   state_reg <= S_PX3;
                S_PX3:
                begin
                    xacc_reg  <= xacc_reg + pos_step;
                    state_reg <= S_PY2;
                end
                S_PY2:   state_reg <= S_PY3;
                S_PY3:
                begin
                    yacc_reg  <= yacc_reg + pos_step;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || pose.ready)
                    begin
                        x_out_reg     <= xacc_reg[39:8];
                        y_out_reg     <= yacc_reg[39:8];
                        h_out_reg     <= heading_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && sample.valid)
        begin
            dcl_reg  <= 17'(signed'(sample.left_count - prev_left_reg));
            dcr_reg  <= 17'(signed'(sample.right_count - prev_right_reg));
            corr_reg <= {sample.gyro_rate[15], sample.gyro_rate}
                        - {gyro_ofs_reg[15], gyro_ofs_reg};
        end
        if (state_reg == S_MR)
        begin
            dl_reg <= prod[DIST_W-1:0];
        end
        if (state_reg == S_DIFF)
        begin
            diff_reg <= {prod[DIST_W-1], prod[DIST_W-1:0]} - {dl_reg[DIST_W-1], dl_reg};
            mean_reg <= dist_sum[DIST_W:1];
        end
        if (state_reg == S_T2)
        begin
            t1_reg <= prod[31:0];
        end
        if (state_reg == S_PX2 || state_reg == S_PY2)
        begin
            p1_reg <= prod;
        end
    end

    assign sample.ready = (state_reg == S_IDLE);
    assign pose.valid   = out_valid_reg;
    assign pose.x_pos   = x_out_reg;
    assign pose.y_pos   = y_out_reg;
    assign pose.heading = h_out_reg;

`ifndef SYNTH
    a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> !sample.ready)
        else $error("second word taken while busy");

    a_cordic_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_start |-> !cres.busy)
        else $error("cordic restarted while busy");

    a_cordic_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cres.done |-> state_reg == S_CWAIT)
        else $error("cordic finished outside wait state");

    a_pose_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pose.valid) |-> $past(state_reg) == S_OUT)
        else $error("pose word raised outside output state");
`endif

endmodule
